FILE: rtl/lld_transport_cell_sweep_macros.svh
// ----------------------------------------------------------------------------
// lld_transport_cell_sweep_macros.svh
// Assertion helpers shared by the checker of the transport cell sweep.
// ----------------------------------------------------------------------------
`ifndef LLD_TRANSPORT_CELL_SWEEP_MACROS_SVH
`define LLD_TRANSPORT_CELL_SWEEP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lld_tcs_pkg.sv
// ----------------------------------------------------------------------------
// lld_tcs_pkg
// Widths, sequencer codes and unit interface types of the transport sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_tcs_pkg;

    // Field widths (Q16.16 fluxes; 16 fraction bits throughout)
    localparam int EDGE_AW    = 6;
    localparam int EDGE_DEPTH = 1 << EDGE_AW;
    localparam int FLUX_W     = 32;
    localparam int MU_W       = 18;
    localparam int LEN_W      = 31;

    // Shared multiplier: 33x33 signed, 64-bit registered product
    localparam int OPND_W = 33;
    localparam int PROD_W = 64;

    // Divider: 63-bit magnitudes, one quotient bit per cycle on each lane
    localparam int MAG_W     = 63;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DIV_LANES = 2;
    localparam int LANE_L    = 0;
    localparam int LANE_R    = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_PREP,
        S_DSTART,
        S_DWAIT,
        S_FINISH
    } t_state;

    // Multiply sequence; each step after the first also consumes the previous step's product
    typedef enum logic [3:0] {
        ST_SH,
        ST_HQL,
        ST_HQR,
        ST_MP,
        ST_MM,
        ST_AA,
        ST_AS1,
        ST_MS2,
        ST_AS2,
        ST_MS1,
        ST_LAST
    } t_step;

    typedef struct packed {
        logic                                start;
        logic [MAG_W-1:0]                    den;
        logic [DIV_LANES-1:0][MAG_W-1:0]     mag;
    } t_div_req;

    typedef struct packed {
        logic                                busy;
        logic [DIV_LANES-1:0]                ovf;
        logic [DIV_LANES-1:0][FLUX_W-1:0]    q;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/lld_tcs_if.sv
// ----------------------------------------------------------------------------
// lld_tcs_if
// Valid/ready channels for cell visits in and node fluxes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_tcs_in_if import lld_tcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [EDGE_AW-1:0]       slot;
    logic signed [MU_W-1:0]   mu;
    logic [LEN_W-1:0]         sigma_total;
    logic [LEN_W-1:0]         cell_len;
    logic signed [FLUX_W-1:0] src_left;
    logic signed [FLUX_W-1:0] src_right;
    logic                     boundary_cell;
    logic signed [FLUX_W-1:0] boundary_in;

    modport source (
        output valid, slot, mu, sigma_total, cell_len, src_left, src_right,
               boundary_cell, boundary_in,
        input  ready
    );
    modport sink (
        input  valid, slot, mu, sigma_total, cell_len, src_left, src_right,
               boundary_cell, boundary_in,
        output ready
    );
endinterface

interface lld_tcs_out_if import lld_tcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FLUX_W-1:0] flux_left;
    logic signed [FLUX_W-1:0] flux_right;
    logic [EDGE_AW-1:0]       slot_out;
    logic                     singular;

    modport source (
        output valid, flux_left, flux_right, slot_out, singular,
        input  ready
    );
    modport sink (
        input  valid, flux_left, flux_right, slot_out, singular,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lld_transport_cell_sweep.sv
// ----------------------------------------------------------------------------
// lld_transport_cell_sweep: 2x2 lumped linear discontinuous cell solve
// Sequence from acceptance: 11 multiply steps, a prep state, a divider start
//   and wait (both skipped on zero determinant), then a finish state.
// Output stalls hold the finish state; input is held off for the whole serial
//   solve.
// Reset clears the sequencer and output valid; the edge flux store is not.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_transport_cell_sweep import lld_tcs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lld_tcs_in_if.sink    i_in,
    lld_tcs_out_if.source o_out
);

    localparam logic [LEN_W-1:0]  A_MAX   = '1;
    localparam logic [FLUX_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FLUX_W-1:0] NEG_MIN = 32'h8000_0000;

    // clamp a 64-bit signed value into 32 bits
    function automatic logic [FLUX_W-1:0] sat32(input logic signed [63:0] x);
        logic [FLUX_W-1:0] r;
        if (x > 64'sd2147483647) begin
            r = POS_MAX;
        end else if (x < -64'sd2147483648) begin
            r = NEG_MIN;
        end else begin
            r = x[FLUX_W-1:0];
        end
        return r;
    endfunction

    // apply sign and saturation to a quotient magnitude
    function automatic logic [FLUX_W-1:0] fix_out(input logic [FLUX_W-1:0] q,
                                                  input logic ovf,
                                                  input logic neg);
        logic [FLUX_W-1:0] r;
        if (!neg) begin
            r = (ovf || q[FLUX_W-1]) ? POS_MAX : q;
        end else begin
            r = (ovf || q > NEG_MIN) ? NEG_MIN : (~q + 1'b1);
        end
        return r;
    endfunction

    t_state r_state, n_state;
    t_step  r_step;
    logic [3:0] step_inc;

    // captured item
    logic [EDGE_AW-1:0]       r_slot;
    logic signed [MU_W-1:0]   r_mu;
    logic [LEN_W-1:0]         r_st;
    logic [LEN_W-1:0]         r_h;
    logic signed [FLUX_W-1:0] r_ql;
    logic signed [FLUX_W-1:0] r_qr;
    logic                     r_bnd;
    logic signed [FLUX_W-1:0] r_bin;

    // intermediate terms
    logic [LEN_W-1:0]         r_a;
    logic signed [47:0]       r_hl;
    logic signed [47:0]       r_hr;
    logic signed [FLUX_W-1:0] r_s1;
    logic signed [FLUX_W-1:0] r_s2;
    logic [MAG_W-1:0]         r_den;
    logic signed [63:0]       r_numl;
    logic signed [63:0]       r_numr;
    logic [MAG_W-1:0]         r_mag_l;
    logic [MAG_W-1:0]         r_mag_r;
    logic                     r_neg_l;
    logic                     r_neg_r;
    logic                     r_sing;

    // result register
    logic                     r_out_valid;
    logic [FLUX_W-1:0]        r_fl;
    logic [FLUX_W-1:0]        r_fr;
    logic [EDGE_AW-1:0]       r_slot_out;
    logic                     r_sing_out;

    logic                     in_fire;
    logic                     out_free;
    logic                     finish_go;
    logic                     div_start;
    logic                     right;
    logic                     den_zero;
    logic [MU_W-1:0]          mu_neg;
    logic [MU_W-1:0]          mu_abs;
    logic [FLUX_W-1:0]        edge_rd;
    logic signed [FLUX_W-1:0] p_in;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [46:0]              a_sum;
    logic [LEN_W-1:0]         a_clamp;
    logic signed [63:0]       hl_x;
    logic signed [63:0]       hr_x;
    logic signed [63:0]       inc_x;
    logic signed [63:0]       s1_right;
    logic signed [63:0]       s2_left;
    logic signed [63:0]       numl_neg;
    logic signed [63:0]       numr_neg;
    logic [FLUX_W-1:0]        fl_fin;
    logic [FLUX_W-1:0]        fr_fin;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_free = ~r_out_valid | o_out.ready;
    assign right    = ~r_mu[MU_W-1];
    assign mu_neg   = -r_mu;
    assign mu_abs   = r_mu[MU_W-1] ? mu_neg : r_mu;
    assign p_in     = r_bnd ? r_bin : edge_rd;
    assign den_zero = (r_den == '0);
    assign step_inc = r_step + 4'd1;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_SH;
        end else begin
            r_state <= n_state;
            if (r_state == S_CALC && r_step != ST_LAST) begin
                r_step <= t_step'(step_inc);
            end else begin
                r_step <= ST_SH;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        finish_go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_CALC;
            end
            S_CALC: begin
                if (r_step == ST_LAST) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = den_zero ? S_FINISH : S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (!div_rsp.busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    finish_go = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // multiplier operand select
    always_comb begin
        unique case (r_step)
            ST_SH: begin
                mul_a = {2'b0, r_st};
                mul_b = {2'b0, r_h};
            end
            ST_HQL: begin
                mul_a = {2'b0, r_h};
                mul_b = {r_ql[FLUX_W-1], r_ql};
            end
            ST_HQR: begin
                mul_a = {2'b0, r_h};
                mul_b = {r_qr[FLUX_W-1], r_qr};
            end
            ST_MP: begin
                mul_a = {{(OPND_W-MU_W){r_mu[MU_W-1]}}, r_mu};
                mul_b = {p_in[FLUX_W-1], p_in};
            end
            ST_MM: begin
                mul_a = {{(OPND_W-MU_W){r_mu[MU_W-1]}}, r_mu};
                mul_b = {{(OPND_W-MU_W){r_mu[MU_W-1]}}, r_mu};
            end
            ST_AA: begin
                mul_a = {2'b0, r_a};
                mul_b = {2'b0, r_a};
            end
            ST_AS1: begin
                mul_a = {2'b0, r_a};
                mul_b = {r_s1[FLUX_W-1], r_s1};
            end
            ST_MS2: begin
                mul_a = {{(OPND_W-MU_W){r_mu[MU_W-1]}}, r_mu};
                mul_b = {r_s2[FLUX_W-1], r_s2};
            end
            ST_AS2: begin
                mul_a = {2'b0, r_a};
                mul_b = {r_s2[FLUX_W-1], r_s2};
            end
            ST_MS1: begin
                mul_a = {{(OPND_W-MU_W){r_mu[MU_W-1]}}, r_mu};
                mul_b = {r_s1[FLUX_W-1], r_s1};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lld_tcs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // product post-processing (floor shifts, clamps)
    assign a_sum    = {29'b0, mu_abs} + prod[62:16];
    assign a_clamp  = (|a_sum[46:LEN_W]) ? A_MAX : a_sum[LEN_W-1:0];
    assign hl_x     = {{16{r_hl[47]}}, r_hl};
    assign hr_x     = {{16{r_hr[47]}}, r_hr};
    assign inc_x    = {{15{prod[63]}}, prod[63:15]};
    assign s1_right = hl_x + inc_x;
    assign s2_left  = hr_x - inc_x;
    assign numl_neg = -r_numl;
    assign numr_neg = -r_numr;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_slot <= i_in.slot;
            r_mu   <= i_in.mu;
            r_st   <= i_in.sigma_total;
            r_h    <= i_in.cell_len;
            r_ql   <= i_in.src_left;
            r_qr   <= i_in.src_right;
            r_bnd  <= i_in.boundary_cell;
            r_bin  <= i_in.boundary_in;
        end
        if (r_state == S_CALC) begin
            unique case (r_step)
                ST_HQL: r_a    <= a_clamp;
                ST_HQR: r_hl   <= prod[63:16];
                ST_MP:  r_hr   <= prod[63:16];
                ST_MM: begin
                    r_s1 <= right ? sat32(s1_right) : sat32(hl_x);
                    r_s2 <= right ? sat32(hr_x) : sat32(s2_left);
                end
                ST_AA:   r_den  <= prod[MAG_W-1:0];
                ST_AS1:  r_den  <= r_den + prod[MAG_W-1:0];
                ST_MS2:  r_numl <= prod;
                ST_AS2:  r_numl <= r_numl - prod;
                ST_MS1:  r_numr <= prod;
                ST_LAST: r_numr <= r_numr + prod;
                default: ;
            endcase
        end
        // sign and magnitude for the divider
        if (r_state == S_PREP) begin
            r_sing  <= den_zero;
            r_neg_l <= r_numl[63];
            r_neg_r <= r_numr[63];
            r_mag_l <= r_numl[63] ? numl_neg[MAG_W-1:0] : r_numl[MAG_W-1:0];
            r_mag_r <= r_numr[63] ? numr_neg[MAG_W-1:0] : r_numr[MAG_W-1:0];
        end
    end

    assign div_req.start       = div_start;
    assign div_req.den         = r_den;
    assign div_req.mag[LANE_L] = r_mag_l;
    assign div_req.mag[LANE_R] = r_mag_r;

    lld_tcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // final fluxes; a singular system gives zeros
    assign fl_fin = r_sing ? '0 :
                    fix_out(div_rsp.q[LANE_L], div_rsp.ovf[LANE_L], r_neg_l);
    assign fr_fin = r_sing ? '0 :
                    fix_out(div_rsp.q[LANE_R], div_rsp.ovf[LANE_R], r_neg_r);

    // downstream node becomes the slot's next incoming flux
    lld_tcs_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (finish_go),
        .i_waddr (r_slot),
        .i_wdata (right ? fr_fin : fl_fin),
        .i_re    (in_fire),
        .i_raddr (i_in.slot),
        .o_rdata (edge_rd)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_go) begin
            r_fl       <= fl_fin;
            r_fr       <= fr_fin;
            r_slot_out <= r_slot;
            r_sing_out <= r_sing;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.flux_left  = r_fl;
    assign o_out.flux_right = r_fr;
    assign o_out.slot_out   = r_slot_out;
    assign o_out.singular   = r_sing_out;

endmodule

`default_nettype wire

FILE: rtl/lld_tcs_mul.sv
// ----------------------------------------------------------------------------
// lld_tcs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_tcs_mul import lld_tcs_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [2*OPND_W-1:0] full;
    logic signed [PROD_W-1:0]   r_prod;

    // all products in use fit in 64 bits signed
    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/lld_tcs_div.sv
// ----------------------------------------------------------------------------
// lld_tcs_div
// Two-lane restoring divider: floor(mag * 2^16 / den), one bit per cycle.
// Both lanes share the divisor; overflow flags a quotient of 2^32 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_tcs_div import lld_tcs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_den;
    logic [MAG_W-1:0]     r_rem [DIV_LANES];
    logic [FLUX_W-1:0]    r_shf [DIV_LANES];
    logic [FLUX_W-1:0]    r_q   [DIV_LANES];
    logic                 r_ovf [DIV_LANES];

    logic [MAG_W:0]       trial [DIV_LANES];
    logic [MAG_W:0]       diff  [DIV_LANES];
    logic                 ge    [DIV_LANES];

    // trial subtract per lane
    always_comb begin
        for (int k = 0; k < DIV_LANES; k++) begin
            trial[k] = {r_rem[k], r_shf[k][FLUX_W-1]};
            diff[k]  = trial[k] - {1'b0, r_den};
            ge[k]    = trial[k] >= {1'b0, r_den};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // lane datapath; the upper dividend bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            for (int k = 0; k < DIV_LANES; k++) begin
                r_rem[k] <= {16'b0, i_req.mag[k][MAG_W-1:16]};
                r_shf[k] <= {i_req.mag[k][15:0], 16'b0};
                r_q[k]   <= '0;
                r_ovf[k] <= {16'b0, i_req.mag[k][MAG_W-1:16]} >= i_req.den;
            end
        end else if (r_busy) begin
            for (int k = 0; k < DIV_LANES; k++) begin
                r_shf[k] <= {r_shf[k][FLUX_W-2:0], 1'b0};
                if (ge[k]) begin
                    r_rem[k] <= diff[k][MAG_W-1:0];
                    r_q[k]   <= {r_q[k][FLUX_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[k][MAG_W-1:0];
                    r_q[k]   <= {r_q[k][FLUX_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        for (int k = 0; k < DIV_LANES; k++) begin
            o_rsp.ovf[k] = r_ovf[k];
            o_rsp.q[k]   = r_q[k];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lld_tcs_mem.sv
// ----------------------------------------------------------------------------
// lld_tcs_mem
// Edge flux store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_tcs_mem import lld_tcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [EDGE_AW-1:0] i_waddr,
    input  logic [FLUX_W-1:0]  i_wdata,
    input  logic               i_re,
    input  logic [EDGE_AW-1:0] i_raddr,
    output logic [FLUX_W-1:0]  o_rdata
);

    logic [FLUX_W-1:0] mem [EDGE_DEPTH];
    logic [FLUX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/lld_tcs_checker.sv
// ----------------------------------------------------------------------------
// lld_tcs_checker
// Port-level checks of the transport cell sweep, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lld_transport_cell_sweep_macros.svh"

module lld_tcs_checker import lld_tcs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FLUX_W-1:0]  i_flux_left,
    input logic [FLUX_W-1:0]  i_flux_right,
    input logic [EDGE_AW-1:0] i_slot_out,
    input logic               i_singular
);

    // busy once a transaction is taken
    `LLD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input ready right after accept")

    // a result only appears while no new item can enter
    `LLD_ASSERT_IMP(a_result_while_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result appeared while idle")

    // singular results carry zero fluxes
    `LLD_ASSERT_IMP(a_singular_zero, i_clk, i_rst_n, i_out_valid && i_singular, i_flux_left == 0 && i_flux_right == 0, "singular result with nonzero flux")

    // stalled result holds
    `LLD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_flux_left) && $stable(i_flux_right) && $stable(i_slot_out) && $stable(i_singular), "stalled result changed")

endmodule

bind lld_transport_cell_sweep lld_tcs_checker u_lld_tcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_flux_left  (o_out.flux_left),
    .i_flux_right (o_out.flux_right),
    .i_slot_out   (o_out.slot_out),
    .i_singular   (o_out.singular)
);

`default_nettype wire

FILE: dv/tb_lld_transport_cell_sweep.sv
// ----------------------------------------------------------------------------
// tb_lld_transport_cell_sweep
// Self-checking bench for the lumped linear discontinuous cell solver. Cell
// visits are driven on the input channel and every node flux result is checked
// against a Q16.16 solver model kept in the bench, including the per-slot
// edge flux memory. Directed corners come first, then random sweeps, a long
// output stall, a run without idling and random mixed traffic.
// ----------------------------------------------------------------------------
module tb_lld_transport_cell_sweep;
    timeunit 1ns;
    timeprecision 1ps;

    import lld_tcs_pkg::*;

    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_LO      = -64'sd2147483648;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_LIMIT = 20000;
    localparam int     SETTLE      = 64;
    localparam int     MAX_REPORTS = 10;

    // One cell visit and one node flux result
    typedef struct packed {
        logic [EDGE_AW-1:0] slot;
        logic [MU_W-1:0]    mu;
        logic [LEN_W-1:0]   sigma_total;
        logic [LEN_W-1:0]   cell_len;
        logic [FLUX_W-1:0]  src_left;
        logic [FLUX_W-1:0]  src_right;
        logic               boundary_cell;
        logic [FLUX_W-1:0]  boundary_in;
    } t_visit;

    typedef struct packed {
        logic [FLUX_W-1:0]  flux_left;
        logic [FLUX_W-1:0]  flux_right;
        logic [EDGE_AW-1:0] slot;
        logic               singular;
    } t_flux;

    logic i_clk;
    logic i_rst_n;

    lld_tcs_in_if  in_if ();
    lld_tcs_out_if out_if ();

    lld_transport_cell_sweep dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // Solver model state
    logic [FLUX_W-1:0] edge_store [EDGE_DEPTH];
    bit                edge_valid [EDGE_DEPTH];
    t_flux             expected_fluxes [$];

    // Traffic control and statistics
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int fail_count;
    int visits_sent;
    int results_seen;
    int singular_seen;
    int saturated_seen;

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Solver model
    // ------------------------------------------------------------------------
    function automatic longint sat32(input longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    // trunc(num * 2^16 / den), clamped to 32 bits; den > 0
    function automatic longint q16_divide(input longint num, input longint den);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] quo;
        neg = (num < 0);
        mag = 128'(neg ? -num : num);
        quo = (mag << 16) / 128'(den);
        if (neg)
            return (quo > 128'h8000_0000) ? SAT_LO : -longint'(quo[63:0]);
        return (quo > 128'h7FFF_FFFF) ? SAT_HI : longint'(quo[63:0]);
    endfunction

    // Solve one cell and update the slot's downstream edge flux
    function automatic t_flux solve_cell(input t_visit v);
        longint m, st, h, ql, qr, p, am, a, hl, hr, inc, s1, s2, den, fl, fr;
        logic   sweep_right;
        t_flux  res;
        m   = longint'($signed(v.mu));
        st  = longint'(v.sigma_total);
        h   = longint'(v.cell_len);
        ql  = longint'($signed(v.src_left));
        qr  = longint'($signed(v.src_right));
        p   = v.boundary_cell ? longint'($signed(v.boundary_in))
                              : longint'($signed(edge_store[v.slot]));
        sweep_right = (m >= 0);
        am  = sweep_right ? m : -m;
        hl  = (h * ql) >>> 16;
        hr  = (h * qr) >>> 16;
        inc = (m * p) >>> 15;
        a   = am + ((st * h) >>> 16);
        if (a > SAT_HI) a = SAT_HI;
        // incoming flux enters the upstream node equation
        if (sweep_right) begin
            s1 = sat32(hl + inc);
            s2 = sat32(hr);
        end else begin
            s1 = sat32(hl);
            s2 = sat32(hr - inc);
        end
        den = a * a + m * m;
        fl  = 0;
        fr  = 0;
        if (den != 0) begin
            fl = q16_divide(a * s1 - m * s2, den);
            fr = q16_divide(a * s2 + m * s1, den);
        end
        edge_store[v.slot] = sweep_right ? fr[31:0] : fl[31:0];
        edge_valid[v.slot] = 1'b1;
        res.flux_left  = fl[31:0];
        res.flux_right = fr[31:0];
        res.slot       = v.slot;
        res.singular   = (den == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random field helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2, 3:    return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    function automatic logic [FLUX_W-1:0] pick_flux();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16);
        endcase
    endfunction

    function automatic logic [MU_W-1:0] pick_mu();
        int mag;
        case ($urandom_range(0, 9))
            0:       mag = 65536;
            1:       mag = 0;
            2, 3:    mag = $urandom_range(0, 65536);
            default: mag = $urandom_range(1000, 65536);
        endcase
        return $urandom_range(0, 1) ? MU_W'(-mag) : MU_W'(mag);
    endfunction

    function automatic t_visit mk_visit(input int slot, input int mu, input logic [30:0] sig,
                                        input logic [30:0] len, input logic [31:0] ql,
                                        input logic [31:0] qr, input bit bnd,
                                        input logic [31:0] bin);
        t_visit v;
        v.slot          = EDGE_AW'(slot);
        v.mu            = MU_W'(mu);
        v.sigma_total   = sig;
        v.cell_len      = len;
        v.src_left      = ql;
        v.src_right     = qr;
        v.boundary_cell = bnd;
        v.boundary_in   = bin;
        return v;
    endfunction

    // Random visit with the given slot and cosine; an unwritten slot gets the boundary
    function automatic t_visit rand_visit(input int slot, input logic [MU_W-1:0] mu,
                                          input bit bnd);
        return mk_visit(slot, int'($signed(mu)), pick_len(), pick_len(), pick_flux(),
                        pick_flux(), bnd || !edge_valid[slot], pick_flux());
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: one transaction, then an optional gap
    // ------------------------------------------------------------------------
    task automatic send_visit(input t_visit v);
        int gap;
        @(negedge i_clk);
        in_if.slot          = v.slot;
        in_if.mu            = v.mu;
        in_if.sigma_total   = v.sigma_total;
        in_if.cell_len      = v.cell_len;
        in_if.src_left      = v.src_left;
        in_if.src_right     = v.src_right;
        in_if.boundary_cell = v.boundary_cell;
        in_if.boundary_in   = v.boundary_in;
        in_if.valid         = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_fluxes.push_back(solve_cell(v));
        visits_sent++;
        if (tx_idle && $urandom_range(0, 99) < 30) begin
            gap = gap_len();
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output ready: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_count;
        stall_left   = 0;
        hold_count   = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready = 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_count = 0;
                    hold_req   = 1'b0;
                end
            end else begin
                if (stall_left == 0 && rx_idle && $urandom_range(0, 99) < 12)
                    stall_left = gap_len();
                if (stall_left > 0) begin
                    out_if.ready = 1'b0;
                    stall_left--;
                end else begin
                    out_if.ready = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic log_failure(input string what, input t_flux want, input t_flux got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH %s: exp L=%h R=%h slot=%0d sing=%b, got L=%h R=%h slot=%0d sing=%b",
                     what, want.flux_left, want.flux_right, want.slot, want.singular,
                     got.flux_left, got.flux_right, got.slot, got.singular);
    endtask

    always @(posedge i_clk) begin : check_result
        t_flux got;
        t_flux want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.flux_left  = out_if.flux_left;
            got.flux_right = out_if.flux_right;
            got.slot       = out_if.slot_out;
            got.singular   = out_if.singular;
            results_seen++;
            if (expected_fluxes.size() == 0) begin
                log_failure("unexpected transaction", '0, got);
            end else begin
                want = expected_fluxes.pop_front();
                if (got.flux_left !== want.flux_left || got.flux_right !== want.flux_right ||
                    got.slot !== want.slot || got.singular !== want.singular)
                    log_failure("node flux", want, got);
                if (want.singular)
                    singular_seen++;
                if (want.flux_left == 32'h7FFF_FFFF || want.flux_left == 32'h8000_0000 ||
                    want.flux_right == 32'h7FFF_FFFF || want.flux_right == 32'h8000_0000)
                    saturated_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Corner cases: both directions, zero cosine, zero determinant, clamps
    task automatic test_directed();
        send_visit(mk_visit(0, 65536, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 1, 1 << 16));
        send_visit(mk_visit(0, 65536, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0));
        send_visit(mk_visit(63, -65536, 2 << 16, 1 << 15, 3 << 16, -(1 << 16), 1, -(3 << 16)));
        send_visit(mk_visit(63, -65536, 2 << 16, 1 << 15, 3 << 16, -(1 << 16), 0, 0));
        // zero determinant: zero cosine and zero optical width
        send_visit(mk_visit(1, 0, 0, 1 << 16, 5 << 16, 5 << 16, 1, 7 << 16));
        send_visit(mk_visit(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        send_visit(mk_visit(2, 0, 1, 1, 1 << 16, 1 << 16, 1, 32'h7FFF_FFFF));
        // zero cosine with some absorption sweeps right
        send_visit(mk_visit(2, 0, 1 << 16, 1 << 16, 2 << 16, -(2 << 16), 0, 0));
        // diagonal clamps
        send_visit(mk_visit(3, 65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1, 32'h7FFF_FFFF));
        send_visit(mk_visit(3, 65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 0, 0));
        // tiny cosine, no absorption: fluxes clamp
        send_visit(mk_visit(4, 1, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                            32'h8000_0000));
        send_visit(mk_visit(5, -1, 0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                            32'h7FFF_FFFF));
        send_visit(mk_visit(5, -1, 0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        // streaming term alone overflows the node source
        send_visit(mk_visit(6, 65536, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
        send_visit(mk_visit(7, -65536, 0, 0, 0, 0, 1, 32'h8000_0000));
        // small negative products exercise floor shifts
        send_visit(mk_visit(62, -65536, 1 << 16, 31'h7FFF_FFFF, -1, -1, 1, -1));
        // direction change on a written slot
        send_visit(mk_visit(62, 32768, 1 << 14, 3 << 16, -1, 1, 0, 0));
        send_visit(mk_visit(7, 65535, 31'h5555_5555, 31'h2AAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 0, 0));
        send_visit(mk_visit(4, -65535, 31'h2AAA_AAAA, 31'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 0, 0));
    endtask

    // Well-formed sweeps: boundary cell, then interior cells in one direction
    task automatic test_sweeps(input int n_visits);
        int               slot;
        int               cells;
        logic [MU_W-1:0]  mu;
        int               sent;
        sent = 0;
        while (sent < n_visits) begin
            slot  = $urandom_range(0, EDGE_DEPTH - 1);
            mu    = pick_mu();
            cells = $urandom_range(3, 12);
            for (int c = 0; c < cells && sent < n_visits; c++) begin
                send_visit(rand_visit(slot, mu, c == 0));
                sent++;
            end
        end
    endtask

    // Mixed traffic: random slots, cosines and boundary flags
    task automatic test_mixed(input int n_visits);
        for (int i = 0; i < n_visits; i++)
            send_visit(rand_visit($urandom_range(0, EDGE_DEPTH - 1), pick_mu(),
                                  $urandom_range(0, 3) == 0));
    endtask

    // Output held off for a long stretch while visits keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_sweeps(10);
        wait (!hold_req);
    endtask

    // Back-to-back transactions with no idling on either side
    task automatic test_no_idle(input int n_visits);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_sweeps(n_visits);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.slot          = '0;
        in_if.mu            = '0;
        in_if.sigma_total   = '0;
        in_if.cell_len      = '0;
        in_if.src_left      = '0;
        in_if.src_right     = '0;
        in_if.boundary_cell = 1'b0;
        in_if.boundary_in   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_sweeps(600);
        test_backpressure();
        test_no_idle(150);
        test_mixed(320);

        @(negedge i_clk);
        in_if.valid = 1'b0;

        // drain, then give the block time to show any stray transaction
        waited = 0;
        while (expected_fluxes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (expected_fluxes.size() != 0)
            log_failure("missing transaction", expected_fluxes.pop_front(), '0);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d cell visits and %0d results: %0d singular, %0d clamped.",
                 visits_sent, results_seen, singular_seen, saturated_seen);
        $display("Traffic included boundary and interior sweeps both ways, a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
